// ===== rtl/core/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared definitions for the tone sequence player
// Field widths, request action codes, register indexes and note types.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Default note store depth
  localparam int MAX_NOTES_DEFAULT = 16;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int FREQ_W   = 16;
  localparam int LEN_W    = 16;
  localparam int STEP_W   = 5;
  localparam int COUNT_W  = 5;
  localparam int PAUSE_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_PLAY = 2'd1,
    ACT_STOP = 2'd2,
    ACT_LOAD = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOTE_COUNT  = 2'd0,
    CFG_PAUSE_TICKS = 2'd1,
    CFG_CYCLIC      = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // One stored note
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
  } note_t;

  // Note store write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    note_t             note;
  } note_wr_t;

endpackage

// ===== rtl/core/tsp_in_if.sv =====
// ----------------------------------------------------------------------------
// tsp_in_if: request channel of the tone sequence player
// Valid/ready handshake carrying one action and its note payload.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tsp_pkg::ACTION_W-1:0] action;
  logic [tsp_pkg::SLOT_W-1:0]   note_slot;
  logic [tsp_pkg::FREQ_W-1:0]   note_frequency;
  logic [tsp_pkg::LEN_W-1:0]    note_duration;

  modport source (output valid, action, note_slot, note_frequency, note_duration,
                  input ready);
  modport sink   (input valid, action, note_slot, note_frequency, note_duration,
                  output ready);
endinterface

// ===== rtl/core/tsp_out_if.sv =====
// ----------------------------------------------------------------------------
// tsp_out_if: result channel of the tone sequence player
// Valid/ready handshake carrying the player status after each request.
// ----------------------------------------------------------------------------
interface tsp_out_if;
  logic                       valid;
  logic                       ready;
  logic [tsp_pkg::FREQ_W-1:0] tone_frequency;
  logic                       busy_res;
  logic                       power_enable;
  logic [tsp_pkg::STEP_W-1:0] step_position;

  modport source (output valid, tone_frequency, busy_res, power_enable, step_position,
                  input ready);
  modport sink   (input valid, tone_frequency, busy_res, power_enable, step_position,
                  output ready);
endinterface

// ===== rtl/core/tsp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tsp_cfg_if: configuration write channel
// Valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsp_pkg::CFG_IDX_W-1:0]  index;
  logic [tsp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tone_sequence_player_core.sv =====
// ----------------------------------------------------------------------------
// tone_sequence_player_core: melody sequencer for a tone output
// Plays a tune from a note store, timed by tick requests.
// ----------------------------------------------------------------------------
// Each request (tick, play, stop or load note) returns exactly one result with
// the driven frequency, busy, power enable and step position. A request is
// taken every clock cycle while the output register is empty or drains; its
// result appears in the next cycle and is held in that register until taken.
// The rate is set by the single state update between the request port and the
// result register; the next note is prefetched from the note store. Notes must
// be loaded before they are played; configuration must be written while no
// request is in flight, which the block itself does not enforce; a change made
// during a tune takes effect at the next note boundary or play request.
module tone_sequence_player_core #(
  parameter int MAX_NOTES = tsp_pkg::MAX_NOTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  tsp_in_if.sink     in_chan,
  tsp_out_if.source  out_chan,
  tsp_cfg_if.sink    cfg_chan
);

  tsp_pkg::note_wr_t          note_wr;
  tsp_pkg::note_t             next_note;
  tsp_pkg::note_t             first_note;
  logic [tsp_pkg::STEP_W-1:0] rd_step;

  // Sequencer control and result register
  tsp_ctrl #(
    .MAX_NOTES (MAX_NOTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_chan   (cfg_chan),
    .next_note  (next_note),
    .first_note (first_note),
    .note_wr    (note_wr),
    .rd_step    (rd_step)
  );

  // Note store
  tsp_note_mem #(
    .MAX_NOTES (MAX_NOTES)
  ) u_note_mem (
    .clk        (clk),
    .wr         (note_wr),
    .rd_step    (rd_step),
    .next_note  (next_note),
    .first_note (first_note)
  );

endmodule

// ===== rtl/core/tsp_note_mem.sv =====
// ----------------------------------------------------------------------------
// tsp_note_mem: note store with next-note prefetch
// Holds frequency and length of each note. Every cycle it reads the entry that
// follows the coming step index, and keeps a shadow copy of note 0, so the
// controller has both candidates for the next note ready from registers.
// ----------------------------------------------------------------------------
module tsp_note_mem #(
  parameter int MAX_NOTES = tsp_pkg::MAX_NOTES_DEFAULT
) (
  input  logic                       clk,
  input  tsp_pkg::note_wr_t          wr,
  input  logic [tsp_pkg::STEP_W-1:0] rd_step,
  output tsp_pkg::note_t             next_note,
  output tsp_pkg::note_t             first_note
);

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int PW = (AW > tsp_pkg::STEP_W + 1) ? AW : tsp_pkg::STEP_W + 1;

  tsp_pkg::note_t mem [MAX_NOTES];
  tsp_pkg::note_t next_note_r;
  tsp_pkg::note_t first_note_r;

  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic          wr_ok;
  logic          rd_hit;

  // Address decode; slots past the store are dropped
  assign rd_addr = PW'(rd_step) + PW'(1);
  assign wr_addr = PW'(wr.slot);
  assign wr_ok   = wr.en && (32'(wr_addr) < 32'(MAX_NOTES));
  assign rd_hit  = wr_ok && (wr_addr == rd_addr);

  // Store write and registered read, new data forwarded on a same-slot write
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr[AW-1:0]] <= wr.note;
    end
    if (rd_hit) begin
      next_note_r <= wr.note;
    end else begin
      next_note_r <= mem[rd_addr[AW-1:0]];
    end
    if (wr_ok && (wr_addr == PW'(0))) begin
      first_note_r <= wr.note;
    end
  end

  assign next_note  = next_note_r;
  assign first_note = first_note_r;

endmodule

// ===== rtl/core/tsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsp_ctrl: tone sequence player control
// Configuration registers, player state, per-request update and the result
// register. One request is handled per cycle while the result register is free or draining.
// ----------------------------------------------------------------------------
module tsp_ctrl #(
  parameter int MAX_NOTES = tsp_pkg::MAX_NOTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tsp_in_if.sink                      in_chan,
  tsp_out_if.source                   out_chan,
  tsp_cfg_if.sink                     cfg_chan,
  input  tsp_pkg::note_t              next_note,
  input  tsp_pkg::note_t              first_note,
  output tsp_pkg::note_wr_t           note_wr,
  output logic [tsp_pkg::STEP_W-1:0]  rd_step
);

  localparam int SW = tsp_pkg::STEP_W;

  // Configuration
  logic [tsp_pkg::COUNT_W-1:0] count_r;
  logic [tsp_pkg::PAUSE_W-1:0] pause_r;
  logic                        cyclic_r;

  // Player state
  logic [SW-1:0]                step_r, step_nxt;
  logic [tsp_pkg::LEN_W-1:0]    ticks_r, ticks_nxt;
  logic                         playing_r, playing_nxt;
  logic [tsp_pkg::FREQ_W-1:0]   freq_r, freq_nxt;

  // Result register
  logic                         out_valid_r;

  logic                         accept;
  logic [SW-1:0]                active_n;
  logic [SW:0]                  step_inc;
  logic [tsp_pkg::LEN_W-1:0]    ticks_dec;
  tsp_pkg::action_t             action;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;
  assign action         = tsp_pkg::action_t'(in_chan.action);

  // Note count clamped to the store depth
  assign active_n = (32'(count_r) > 32'(MAX_NOTES)) ? SW'(MAX_NOTES) : SW'(count_r);
  assign step_inc = {1'b0, step_r} + (SW+1)'(1);
  assign ticks_dec = (ticks_r != '0) ? ticks_r - tsp_pkg::LEN_W'(1) : ticks_r;

  // Load request to the note store
  assign note_wr.en        = accept && (action == tsp_pkg::ACT_LOAD);
  assign note_wr.slot      = in_chan.note_slot;
  assign note_wr.note.freq = in_chan.note_frequency;
  assign note_wr.note.len  = in_chan.note_duration;

  // Prefetch address follows the coming step
  assign rd_step = step_nxt;

  // Next player state
  always_comb begin
    step_nxt    = step_r;
    ticks_nxt   = ticks_r;
    playing_nxt = playing_r;
    freq_nxt    = freq_r;
    if (accept) begin
      case (action)
        tsp_pkg::ACT_TICK: begin
          if (playing_r) begin
            ticks_nxt = ticks_dec;
            if (ticks_dec == '0) begin
              // Note boundary
              if (step_inc < {1'b0, active_n}) begin
                step_nxt  = step_inc[SW-1:0];
                freq_nxt  = next_note.freq;
                ticks_nxt = (next_note.len == '0) ? tsp_pkg::LEN_W'(1) : next_note.len;
              end else if (step_inc == {1'b0, active_n} && pause_r != '0) begin
                step_nxt  = active_n;
                freq_nxt  = '0;
                ticks_nxt = pause_r;
              end else if (cyclic_r && active_n != '0) begin
                step_nxt  = '0;
                freq_nxt  = first_note.freq;
                ticks_nxt = (first_note.len == '0) ? tsp_pkg::LEN_W'(1) : first_note.len;
              end else begin
                step_nxt    = active_n;
                playing_nxt = 1'b0;
                freq_nxt    = '0;
                ticks_nxt   = '0;
              end
            end
          end
        end
        tsp_pkg::ACT_PLAY: begin
          if (!(playing_r && cyclic_r)) begin
            step_nxt = '0;
            if (active_n != '0) begin
              playing_nxt = 1'b1;
              freq_nxt    = first_note.freq;
              ticks_nxt   = (first_note.len == '0) ? tsp_pkg::LEN_W'(1) : first_note.len;
            end else begin
              playing_nxt = 1'b0;
              freq_nxt    = '0;
              ticks_nxt   = '0;
            end
          end
        end
        tsp_pkg::ACT_STOP: begin
          playing_nxt = 1'b0;
          freq_nxt    = '0;
          ticks_nxt   = '0;
        end
        default: begin
          // Load note touches only the store
        end
      endcase
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      ticks_r   <= '0;
      playing_r <= 1'b0;
      freq_r    <= '0;
      count_r   <= '0;
      pause_r   <= '0;
      cyclic_r  <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      ticks_r   <= ticks_nxt;
      playing_r <= playing_nxt;
      freq_r    <= freq_nxt;
      if (cfg_chan.valid) begin
        case (tsp_pkg::cfg_idx_t'(cfg_chan.index))
          tsp_pkg::CFG_NOTE_COUNT:  count_r  <= cfg_chan.data[tsp_pkg::COUNT_W-1:0];
          tsp_pkg::CFG_PAUSE_TICKS: pause_r  <= cfg_chan.data[tsp_pkg::PAUSE_W-1:0];
          tsp_pkg::CFG_CYCLIC:      cyclic_r <= cfg_chan.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  // Result payload, loaded with the state after each request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_chan.tone_frequency <= freq_nxt;
      out_chan.busy_res       <= playing_nxt;
      out_chan.power_enable   <= playing_nxt;
      out_chan.step_position  <= step_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tone_sequence_player_core
// Drives tick, play, stop and load-note requests with random idling on both
// channels, predicts each status result in a scoreboard class and compares
// it field by field. It runs through several register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NOTE_SLOTS   = tsp_pkg::MAX_NOTES_DEFAULT;
  localparam int HALF_PERIOD  = 10;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 260;

  typedef logic [tsp_pkg::SLOT_W-1:0]     slot_t;
  typedef logic [tsp_pkg::FREQ_W-1:0]     freq_t;
  typedef logic [tsp_pkg::LEN_W-1:0]      len_t;
  typedef logic [tsp_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // One status result as seen on the output channel
  typedef struct packed {
    logic [tsp_pkg::FREQ_W-1:0] freq;
    logic                       busy;
    logic                       power;
    logic [tsp_pkg::STEP_W-1:0] step;
  } tone_status_t;

  // Player state tracker and status checker
  class tone_status_board;
    bit [tsp_pkg::FREQ_W-1:0]  freq_mem [NOTE_SLOTS];
    bit [tsp_pkg::LEN_W-1:0]   len_mem  [NOTE_SLOTS];
    bit [tsp_pkg::STEP_W-1:0]  step;
    bit [tsp_pkg::LEN_W-1:0]   ticks;
    bit                        playing;
    bit [tsp_pkg::FREQ_W-1:0]  driven;
    bit [tsp_pkg::COUNT_W-1:0] note_count;
    bit [tsp_pkg::PAUSE_W-1:0] pause;
    bit                        cyclic;
    tone_status_t              status_q [$];
    int                        mismatches;
    int                        results_checked;
    int                        requests_seen;

    function int pending();
      return status_q.size();
    endfunction

    function int active_notes();
      return (note_count > NOTE_SLOTS) ? NOTE_SLOTS : int'(note_count);
    endfunction

    function void set_register(tsp_pkg::cfg_idx_t idx, cfg_data_t data);
      case (idx)
        tsp_pkg::CFG_NOTE_COUNT:  note_count = data[tsp_pkg::COUNT_W-1:0];
        tsp_pkg::CFG_PAUSE_TICKS: pause = data[tsp_pkg::PAUSE_W-1:0];
        tsp_pkg::CFG_CYCLIC:      cyclic = data[0];
        default: ;
      endcase
    endfunction

    function void begin_note(int idx);
      step = idx[tsp_pkg::STEP_W-1:0];
      driven = freq_mem[idx];
      ticks = (len_mem[idx] == 0) ? len_t'(1) : len_mem[idx];
    endfunction

    function void go_silent();
      playing = 1'b0;
      driven = '0;
      ticks = '0;
    endfunction

    // Current note ran out: next note, pause, loop or end of tune
    function void note_done();
      int n;
      n = active_notes();
      if (int'(step) + 1 < n) begin
        begin_note(int'(step) + 1);
      end else if (int'(step) + 1 == n && pause != 0) begin
        step = n[tsp_pkg::STEP_W-1:0];
        driven = '0;
        ticks = pause;
      end else if (cyclic && n != 0) begin
        begin_note(0);
      end else begin
        step = n[tsp_pkg::STEP_W-1:0];
        go_silent();
      end
    endfunction

    function void note_request(tsp_pkg::action_t act, slot_t slot,
                               freq_t freq, len_t dur);
      tone_status_t st;
      requests_seen++;
      case (act)
        tsp_pkg::ACT_TICK: begin
          if (playing) begin
            if (ticks != 0) ticks--;
            if (ticks == 0) note_done();
          end
        end
        tsp_pkg::ACT_PLAY: begin
          if (!(playing && cyclic)) begin
            go_silent();
            step = '0;
            if (active_notes() != 0) begin
              playing = 1'b1;
              begin_note(0);
            end
          end
        end
        tsp_pkg::ACT_STOP: go_silent();
        default: begin
          freq_mem[slot] = freq;
          len_mem[slot] = dur;
        end
      endcase
      st.freq = driven;
      st.busy = playing;
      st.power = playing;
      st.step = step;
      status_q.push_back(st);
    endfunction

    function void check_result(tone_status_t got);
      tone_status_t exp_st;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: freq=%0d busy=%0b pwr=%0b step=%0d",
                   $time, got.freq, got.busy, got.power, got.step);
        return;
      end
      exp_st = status_q.pop_front();
      results_checked++;
      if (got.freq !== exp_st.freq || got.busy !== exp_st.busy ||
          got.power !== exp_st.power || got.step !== exp_st.step) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d: expected freq=%0d busy=%0b pwr=%0b step=%0d,",
                   $time, results_checked, exp_st.freq, exp_st.busy, exp_st.power,
                   exp_st.step);
          $display("  got freq=%0d busy=%0b pwr=%0b step=%0d",
                   got.freq, got.busy, got.power, got.step);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tsp_in_if  in_if ();
  tsp_out_if out_if ();
  tsp_cfg_if cfg_if ();

  tone_sequence_player_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  tone_status_board sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          start_hold;
  int          hold_left;
  int          cfg_writes;
  int          phases_run;

  // Clock
  always #HALF_PERIOD clk = ~clk;

  // Result side ready, with random idling and the long hold-off
  always @(negedge clk) begin
    if (start_hold) begin
      start_hold = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: note accepted requests, then check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_request(tsp_pkg::action_t'(in_if.action), in_if.note_slot,
                        in_if.note_frequency, in_if.note_duration);
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.tone_frequency, out_if.busy_res,
                         out_if.power_enable, out_if.step_position});
    end
  end

  // One request, with random idle cycles ahead of it
  task automatic send_req(tsp_pkg::action_t act, slot_t slot, freq_t freq, len_t dur);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.action <= tsp_pkg::action_t'($urandom_range(3));
      in_if.note_slot <= slot_t'($urandom_range(NOTE_SLOTS - 1));
      in_if.note_frequency <= freq_t'($urandom_range(16'hFFFF));
      in_if.note_duration <= len_t'($urandom_range(16'hFFFF));
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.note_slot <= slot;
    in_if.note_frequency <= freq;
    in_if.note_duration <= dur;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Wait until every expected result is back, then let the pipe settle
  task automatic wait_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(tsp_pkg::cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_tune(int count, int pause_len, bit loop_on);
    wait_drain();
    write_reg(tsp_pkg::CFG_NOTE_COUNT, cfg_data_t'(count));
    write_reg(tsp_pkg::CFG_PAUSE_TICKS, cfg_data_t'(pause_len));
    write_reg(tsp_pkg::CFG_CYCLIC, cfg_data_t'(loop_on));
  endtask

  // Durations are mostly short so tunes advance; a few use the full range
  function automatic len_t pick_duration();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return len_t'($urandom_range(3));
    if (r < 90) return len_t'($urandom_range(20));
    return len_t'($urandom_range(16'hFFFF));
  endfunction

  function automatic freq_t pick_frequency();
    return ($urandom_range(7) == 0) ? '0 : freq_t'($urandom_range(16'hFFFF));
  endfunction

  task automatic load_all_slots();
    for (int s = 0; s < NOTE_SLOTS; s++)
      send_req(tsp_pkg::ACT_LOAD, slot_t'(s), pick_frequency(), pick_duration());
  endtask

  // Mostly ticks; plays, stops and reloads break the tune up now and then
  task automatic random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)
      send_req(tsp_pkg::ACT_TICK, slot_t'($urandom_range(NOTE_SLOTS - 1)),
               freq_t'($urandom_range(16'hFFFF)), len_t'($urandom_range(16'hFFFF)));
    else if (r < 78)
      send_req(tsp_pkg::ACT_PLAY, slot_t'($urandom_range(NOTE_SLOTS - 1)),
               freq_t'($urandom_range(16'hFFFF)), len_t'($urandom_range(16'hFFFF)));
    else if (r < 82)
      send_req(tsp_pkg::ACT_STOP, slot_t'($urandom_range(NOTE_SLOTS - 1)),
               freq_t'($urandom_range(16'hFFFF)), len_t'($urandom_range(16'hFFFF)));
    else
      send_req(tsp_pkg::ACT_LOAD, slot_t'($urandom_range(NOTE_SLOTS - 1)),
               pick_frequency(), pick_duration());
  endtask

  task automatic run_phase(int count, int pause_len, bit loop_on,
                           int unsigned s_idle, int unsigned r_idle, bit hold);
    set_tune(count, pause_len, loop_on);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    phases_run++;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (hold && i == PHASE_ITEMS / 4) start_hold = 1'b1;
      random_request();
    end
  endtask

  // Run limit
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = tsp_pkg::ACT_TICK;
    in_if.note_slot = '0;
    in_if.note_frequency = '0;
    in_if.note_duration = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = tsp_pkg::CFG_NOTE_COUNT;
    cfg_if.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_hold = 1'b0;
    hold_left = 0;
    cfg_writes = 0;
    phases_run = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: play with an empty tune, tick while idle
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    send_req(tsp_pkg::ACT_TICK, 0, 0, 0);

    // Three notes with a two-tick pause, played once
    set_tune(3, 2, 1'b0);
    send_req(tsp_pkg::ACT_LOAD, 0, 16'hFFFF, 0);
    send_req(tsp_pkg::ACT_LOAD, 1, 0, 2);
    send_req(tsp_pkg::ACT_LOAD, 2, 16'h8001, 1);
    send_req(tsp_pkg::ACT_LOAD, 15, 16'hFFFF, 16'hFFFF);
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    repeat (7) send_req(tsp_pkg::ACT_TICK, 0, 0, 0);
    send_req(tsp_pkg::ACT_TICK, 0, 0, 0);
    // Play while busy restarts when not cyclic; stop then tick
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    send_req(tsp_pkg::ACT_TICK, 0, 0, 0);
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    send_req(tsp_pkg::ACT_STOP, 0, 0, 0);
    send_req(tsp_pkg::ACT_TICK, 0, 0, 0);

    // Cyclic without pause: loop back to note 0, play while busy ignored
    set_tune(3, 0, 1'b1);
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    repeat (4) send_req(tsp_pkg::ACT_TICK, 0, 0, 0);
    send_req(tsp_pkg::ACT_PLAY, 0, 0, 0);
    send_req(tsp_pkg::ACT_STOP, 0, 0, 0);

    // Random phases over several settings and idling patterns
    wait_drain();
    load_all_slots();
    run_phase(4, 0, 1'b0, 30, 66, 1'b0);
    run_phase(16, 3, 1'b1, 30, 66, 1'b1);
    run_phase(1, 16'hFFFF, 1'b0, 66, 30, 1'b0);
    run_phase(25, 1, 1'b1, 66, 30, 1'b0);
    run_phase(0, 2, 1'b1, 0, 0, 1'b0);
    run_phase(7, 2, 1'b0, 0, 0, 1'b0);

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d checked results over %0d register writes",
             sb.requests_seen, sb.results_checked, cfg_writes);
    $display("(%0d random phases with idling, hold-off and note counts up to 25).",
             phases_run);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tsp_pkg.sv
rtl/core/tsp_in_if.sv
rtl/core/tsp_out_if.sv
rtl/core/tsp_cfg_if.sv
rtl/core/tsp_note_mem.sv
rtl/core/tsp_ctrl.sv
rtl/core/tone_sequence_player_core.sv
dv/testbench.sv
